[rtl/assert_macros.svh]
// Assertion macros used by the fetch core RTL.
// No dependencies; expects clk and rst_n in the including scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising clock edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Condition that must never be true outside reset.
`define ASSERT_NEVER(label, cond, msg) \
  `ASSERT_CLK(label, !(cond), msg)

`endif

[rtl/twf_pkg.sv]
// Shared constants and types for the wrapped tile window fetch block.
// No dependencies.
package twf_pkg;

  // Command codes
  localparam logic [1:0] CMD_WRITE  = 2'd0;
  localparam logic [1:0] CMD_REGION = 2'd1;
  localparam logic [1:0] CMD_LOCATE = 2'd2;

  // Configuration register indexes
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_MAP_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAP_HEIGHT = 2'd1;

  localparam int DIM_REG_W = 7;   // map_width / map_height register width
  localparam int CELL_W    = 8;
  localparam int POS_W     = 8;
  localparam int RAD_W     = 4;

  // Window origin is pos - radius: 9-bit signed, magnitude fits 8 bits
  localparam int VAL_W = POS_W + 1;
  localparam int MAG_W = POS_W;

  localparam logic [CELL_W-1:0] SPACE_CHAR = 8'd32;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_WRAP = 4'b0010,
    ST_SCAN = 4'b0100,
    ST_ONE  = 4'b1000
  } twf_state_t;

endpackage

[rtl/twf_ram.sv]
// Generic single-clock RAM: one write port, one read port, registered read.
// No dependencies.
module twf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rd_data_r <= mem[raddr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

[rtl/twf_wrap.sv]
// Serial true-modulo unit: remainder of a signed window origin by the map size.
// One quotient bit per cycle, then a sign fix-up. Depends on twf_pkg.
module twf_wrap #(
  parameter int EW    = 7,
  parameter int DIM_W = 6
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  input  logic signed [twf_pkg::VAL_W-1:0] val,
  input  logic [EW-1:0]                   modulus,
  output logic                            done,
  output logic [DIM_W-1:0]                rem
);

  localparam int MAG_W = twf_pkg::MAG_W;
  localparam int CNT_W = $clog2(MAG_W);

  logic                busy_r, busy_nxt;
  logic                fix_r, fix_nxt;
  logic                done_r, done_nxt;
  logic                neg_r, neg_nxt;
  logic [MAG_W-1:0]    mag_r, mag_nxt;
  logic [EW-1:0]       rem_r, rem_nxt;
  logic [EW-1:0]       mod_r, mod_nxt;
  logic [CNT_W-1:0]    cnt_r, cnt_nxt;

  logic [twf_pkg::VAL_W-1:0] val_abs;
  logic [EW:0]               trial;
  logic [EW:0]               diff;

  always_comb begin
    val_abs  = val[twf_pkg::VAL_W-1] ? (-val) : val;
    trial    = {rem_r, mag_r[MAG_W-1]};
    diff     = trial - {1'b0, mod_r};
    busy_nxt = busy_r;
    fix_nxt  = fix_r;
    done_nxt = 1'b0;
    neg_nxt  = neg_r;
    mag_nxt  = mag_r;
    rem_nxt  = rem_r;
    mod_nxt  = mod_r;
    cnt_nxt  = cnt_r;
    if (start) begin
      busy_nxt = 1'b1;
      fix_nxt  = 1'b0;
      neg_nxt  = val[twf_pkg::VAL_W-1];
      mag_nxt  = val_abs[MAG_W-1:0];
      rem_nxt  = '0;
      mod_nxt  = modulus;
      cnt_nxt  = '0;
    end else if (busy_r && !fix_r) begin
      rem_nxt = (trial >= {1'b0, mod_r}) ? diff[EW-1:0] : trial[EW-1:0];
      mag_nxt = {mag_r[MAG_W-2:0], 1'b0};
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == CNT_W'(MAG_W - 1)) begin
        fix_nxt = 1'b1;
      end
    end else if (busy_r) begin
      // negative origin: fold remainder back into 0..m-1
      if (neg_r && (rem_r != '0)) begin
        rem_nxt = mod_r - rem_r;
      end
      busy_nxt = 1'b0;
      fix_nxt  = 1'b0;
      done_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      fix_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      fix_r  <= fix_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    neg_r <= neg_nxt;
    mag_r <= mag_nxt;
    rem_r <= rem_nxt;
    mod_r <= mod_nxt;
  end

  assign done = done_r;
  assign rem  = rem_r[DIM_W-1:0];

endmodule

[rtl/wrapped_tile_window_fetch_core.sv]
// Wrapped tile window fetch: byte tile map in one RAM, window and cell reads.
// Uses twf_pkg, twf_ram, twf_wrap and assert_macros.svh.
//
// A write gives no word. A location read passes through state ST_ONE, the
// RAM read register and the output register and gives one word. A region
// read first folds the window origin into the map in two serial modulo
// units, then issues one RAM read per cycle, so it delivers (2r+1)^2 words
// at one word per cycle while the output side keeps up; a radius above
// MAX_RADIUS gives a single error word instead. The single RAM read port
// sets the pace of the scan.
// A new command is taken only once the previous one has issued its last
// read; the map needs no clearing after reset, and reading a cell that was
// never written returns an undefined byte.
module wrapped_tile_window_fetch_core #(
  parameter int MAX_RADIUS  = 3,
  parameter int MAP_DIM_MAX = 64
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // configuration
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [twf_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [twf_pkg::DIM_REG_W-1:0]       cfg_data,
  // command words
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [1:0]                          in_cmd,
  input  logic signed [twf_pkg::POS_W-1:0]    in_pos_x,
  input  logic signed [twf_pkg::POS_W-1:0]    in_pos_y,
  input  logic [twf_pkg::RAD_W-1:0]           in_radius,
  input  logic [twf_pkg::CELL_W-1:0]          in_cell_in,
  // result words
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [twf_pkg::CELL_W-1:0]          out_cell_res,
  output logic                                out_last,
  output logic                                out_error
);

  `include "assert_macros.svh"

  localparam int DIM_W = $clog2(MAP_DIM_MAX);
  localparam int EW    = DIM_W + 1;
  localparam int CW    = (EW > twf_pkg::DIM_REG_W) ? EW : twf_pkg::DIM_REG_W;
  localparam int AW    = 2 * DIM_W;
  localparam int DEPTH = 1 << AW;
  localparam int CNT_W = $clog2(2 * MAX_RADIUS + 2);

  // ---------------- configuration ----------------
  logic [twf_pkg::DIM_REG_W-1:0] map_w_r, map_h_r;
  logic [EW-1:0]                 w_eff, h_eff;

  function automatic logic [EW-1:0] clamp_dim(input logic [twf_pkg::DIM_REG_W-1:0] r);
    logic [CW-1:0] rx;
    rx = CW'(r);
    if (rx == '0) begin
      return EW'(1);
    end else if (rx > CW'(MAP_DIM_MAX)) begin
      return EW'(MAP_DIM_MAX);
    end
    return EW'(rx);
  endfunction

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      map_w_r <= 7'd64;
      map_h_r <= 7'd64;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        twf_pkg::REG_MAP_WIDTH:  map_w_r <= cfg_data;
        twf_pkg::REG_MAP_HEIGHT: map_h_r <= cfg_data;
        default: ;
      endcase
    end
  end

  assign w_eff = clamp_dim(map_w_r);
  assign h_eff = clamp_dim(map_h_r);

  // ---------------- command decode ----------------
  twf_pkg::twf_state_t st_r, st_nxt;

  logic in_acc, x_ok, y_ok, in_bounds, rad_ok;
  logic signed [twf_pkg::VAL_W-1:0] org_x, org_y;

  assign in_ready  = (st_r == twf_pkg::ST_IDLE);
  assign in_acc    = in_valid && in_ready;
  assign x_ok      = !in_pos_x[twf_pkg::POS_W-1] &&
                     (CW'(in_pos_x[twf_pkg::POS_W-2:0]) < CW'(w_eff));
  assign y_ok      = !in_pos_y[twf_pkg::POS_W-1] &&
                     (CW'(in_pos_y[twf_pkg::POS_W-2:0]) < CW'(h_eff));
  assign in_bounds = x_ok && y_ok;
  assign rad_ok    = (in_radius <= twf_pkg::RAD_W'(MAX_RADIUS));
  assign org_x     = {in_pos_x[twf_pkg::POS_W-1], in_pos_x} - {1'b0, 4'b0, in_radius};
  assign org_y     = {in_pos_y[twf_pkg::POS_W-1], in_pos_y} - {1'b0, 4'b0, in_radius};

  // ---------------- origin wrap units ----------------
  logic             wrap_start, wx_done, wy_done;
  logic [DIM_W-1:0] wx_rem, wy_rem;

  assign wrap_start = in_acc && (in_cmd == twf_pkg::CMD_REGION) && rad_ok;

  twf_wrap #(.EW(EW), .DIM_W(DIM_W)) u_wrap_x (
    .clk(clk), .rst_n(rst_n), .start(wrap_start), .val(org_x), .modulus(w_eff),
    .done(wx_done), .rem(wx_rem)
  );

  twf_wrap #(.EW(EW), .DIM_W(DIM_W)) u_wrap_y (
    .clk(clk), .rst_n(rst_n), .start(wrap_start), .val(org_y), .modulus(h_eff),
    .done(wy_done), .rem(wy_rem)
  );

  // ---------------- sequencer ----------------
  logic [DIM_W-1:0] col_r, col_nxt, row_r, row_nxt, col0_r, col0_nxt;
  logic [CNT_W-1:0] ccnt_r, ccnt_nxt, rcnt_r, rcnt_nxt, dm1_r, dm1_nxt;
  logic [AW-1:0]    addr_r, addr_nxt;
  logic             one_read_r, one_read_nxt, one_space_r, one_space_nxt;
  logic             one_err_r, one_err_nxt;

  logic rd_pend_r, pend_last_r, pend_err_r, pend_space_r;
  logic out_valid_r, out_last_r, out_error_r;
  logic [twf_pkg::CELL_W-1:0] out_cell_r, ram_rd_data;

  logic move, slot_free, issue, scan_last, issue_last;
  logic ram_we, ram_re;
  logic [AW-1:0] ram_waddr, ram_raddr;

  assign move       = rd_pend_r && (!out_valid_r || out_ready);
  assign slot_free  = !rd_pend_r || move;
  assign issue      = slot_free && ((st_r == twf_pkg::ST_SCAN) || (st_r == twf_pkg::ST_ONE));
  assign scan_last  = (ccnt_r == dm1_r) && (rcnt_r == dm1_r);
  assign issue_last = (st_r == twf_pkg::ST_ONE) || scan_last;
  assign ram_re     = issue && ((st_r == twf_pkg::ST_SCAN) || one_read_r);
  assign ram_raddr  = (st_r == twf_pkg::ST_SCAN) ? {row_r, col_r} : addr_r;
  assign ram_we     = in_acc && (in_cmd == twf_pkg::CMD_WRITE) && in_bounds;
  assign ram_waddr  = {in_pos_y[DIM_W-1:0], in_pos_x[DIM_W-1:0]};

  always_comb begin
    st_nxt        = st_r;
    col_nxt       = col_r;
    row_nxt       = row_r;
    col0_nxt      = col0_r;
    ccnt_nxt      = ccnt_r;
    rcnt_nxt      = rcnt_r;
    dm1_nxt       = dm1_r;
    addr_nxt      = addr_r;
    one_read_nxt  = one_read_r;
    one_space_nxt = one_space_r;
    one_err_nxt   = one_err_r;
    case (st_r)
      twf_pkg::ST_IDLE: begin
        if (in_acc) begin
          case (in_cmd)
            twf_pkg::CMD_REGION: begin
              dm1_nxt = CNT_W'({in_radius, 1'b0});
              if (rad_ok) begin
                st_nxt = twf_pkg::ST_WRAP;
              end else begin
                one_read_nxt  = 1'b0;
                one_space_nxt = 1'b0;
                one_err_nxt   = 1'b1;
                st_nxt        = twf_pkg::ST_ONE;
              end
            end
            twf_pkg::CMD_LOCATE: begin
              addr_nxt      = ram_waddr;
              one_read_nxt  = in_bounds;
              one_space_nxt = !in_bounds;
              one_err_nxt   = 1'b0;
              st_nxt        = twf_pkg::ST_ONE;
            end
            default: ;
          endcase
        end
      end
      twf_pkg::ST_WRAP: begin
        if (wx_done) begin
          col0_nxt = wx_rem;
          col_nxt  = wx_rem;
          row_nxt  = wy_rem;
          ccnt_nxt = '0;
          rcnt_nxt = '0;
          st_nxt   = twf_pkg::ST_SCAN;
        end
      end
      twf_pkg::ST_SCAN: begin
        if (issue) begin
          if (scan_last) begin
            st_nxt = twf_pkg::ST_IDLE;
          end else if (ccnt_r == dm1_r) begin
            ccnt_nxt = '0;
            col_nxt  = col0_r;
            rcnt_nxt = rcnt_r + 1'b1;
            row_nxt  = ({1'b0, row_r} == h_eff - EW'(1)) ? '0 : row_r + 1'b1;
          end else begin
            ccnt_nxt = ccnt_r + 1'b1;
            col_nxt  = ({1'b0, col_r} == w_eff - EW'(1)) ? '0 : col_r + 1'b1;
          end
        end
      end
      twf_pkg::ST_ONE: begin
        if (issue) begin
          st_nxt = twf_pkg::ST_IDLE;
        end
      end
      default: st_nxt = twf_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= twf_pkg::ST_IDLE;
    end else begin
      st_r <= st_nxt;
    end
    col_r       <= col_nxt;
    row_r       <= row_nxt;
    col0_r      <= col0_nxt;
    ccnt_r      <= ccnt_nxt;
    rcnt_r      <= rcnt_nxt;
    dm1_r       <= dm1_nxt;
    addr_r      <= addr_nxt;
    one_read_r  <= one_read_nxt;
    one_space_r <= one_space_nxt;
    one_err_r   <= one_err_nxt;
  end

  // ---------------- map memory ----------------
  twf_ram #(.WIDTH(twf_pkg::CELL_W), .DEPTH(DEPTH)) u_map (
    .clk(clk), .we(ram_we), .waddr(ram_waddr), .wdata(in_cell_in),
    .re(ram_re), .raddr(ram_raddr), .rd_data(ram_rd_data)
  );

  // ---------------- read slot and output register ----------------
  // RAM read register holds an issued word until the output register frees up.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_pend_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (issue) begin
        rd_pend_r <= 1'b1;
      end else if (move) begin
        rd_pend_r <= 1'b0;
      end
      if (move) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
    if (issue) begin
      pend_last_r  <= issue_last;
      pend_err_r   <= (st_r == twf_pkg::ST_ONE) && one_err_r;
      pend_space_r <= (st_r == twf_pkg::ST_ONE) && one_space_r;
    end
    if (move) begin
      out_cell_r  <= pend_space_r ? twf_pkg::SPACE_CHAR :
                     (pend_err_r ? '0 : ram_rd_data);
      out_last_r  <= pend_last_r;
      out_error_r <= pend_err_r;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_cell_res = out_cell_r;
  assign out_last     = out_last_r;
  assign out_error    = out_error_r;

  // ---------------- assertions ----------------
  logic scan_in_map, scan_done;

  assign scan_in_map = ({1'b0, col_r} < w_eff) && ({1'b0, row_r} < h_eff);
  assign scan_done   = (st_r == twf_pkg::ST_SCAN) && issue && scan_last;

  `ASSERT_CLK(a_wrap_sync, wx_done == wy_done, "wrap units out of step")
  `ASSERT_NEVER(a_rw_overlap, ram_we && ram_re, "map write and read in one cycle")
  `ASSERT_CLK(a_scan_range, (st_r == twf_pkg::ST_SCAN) |-> scan_in_map, "window cell outside map")
  `ASSERT_CLK(a_scan_end, scan_done |=> (st_r == twf_pkg::ST_IDLE), "region scan did not finish")

endmodule
